[rtl/ffa_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

    // Position arithmetic width: a header address plus a header and a 15-bit size
    localparam int unsigned POS_W     = 17;
    localparam int unsigned SIZE_W    = 15;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned LIMIT_W   = 13;
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned REQ_W     = 16;

    // Header word layout
    localparam int unsigned USED_BIT  = 15;

    // An allocate of size zero takes this size
    localparam logic [REQ_W-1:0] ZERO_SIZE = 16'd4;

    // Reset value of the heap limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_OOM     = 2'd2
    } t_status;

endpackage

[rtl/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator: request sequencer around the heap RAM.
//
// Usage:
//   Requests enter on i_valid/o_ready with i_mode (0 allocate, 1 free),
//   i_request_size and i_block_address. Each request gives one result
//   transaction on o_valid/i_ready with o_data_address and o_status.
//   i_cfg_we writes i_cfg_wdata into the heap limit register; write it only
//   while no request is in flight.
// Sequencing:
//   One request at a time. Each header read takes an address state, then
//   a data state. An allocate walks headers from the first free pointer and
//   extends the heap, reuses a block or splits one, and may rescan the first
//   free pointer past used blocks. A free reads the block header and merges
//   free neighbors forward; a refused size or a null free goes to the result
//   directly. A non power of two ALIGN_UNIT adds a rounding state.
// Reset:
//   i_rst_n is synchronous, active low. After reset, S_INIT writes the end
//   marker at heap word 0; the first free pointer is zero, the limit 4096.
// Stall:
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its result waits until the register is free.
module first_fit_heap_allocator_unit #(
    parameter int unsigned HEAP_DEPTH   = 4096,
    parameter int unsigned HEADER_WORDS = 2,
    parameter int unsigned ALIGN_UNIT   = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [ffa_pkg::REQ_W-1:0]     i_request_size,
    input  logic [ffa_pkg::ADDR_W-1:0]    i_block_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ffa_pkg::ADDR_W-1:0]    o_data_address,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic [ffa_pkg::LIMIT_W-1:0]   i_cfg_wdata
);

    localparam int unsigned AW  = $clog2(HEAP_DEPTH);
    localparam int unsigned PW  = ffa_pkg::POS_W;
    localparam int unsigned SW  = ffa_pkg::SIZE_W;
    localparam int unsigned WW  = ffa_pkg::WORD_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(HEAP_DEPTH);
    localparam logic [PW-1:0] HDR_P   = PW'(HEADER_WORDS);
    localparam logic [PW-1:0] ALIGN_P = PW'(ALIGN_UNIT);
    localparam bit            ALIGN_POW2 = ((ALIGN_UNIT & (ALIGN_UNIT - 1)) == 0);
    // Reciprocal of the alignment unit, exact for sizes below 2^16
    localparam int unsigned   RECIP_SH = 20;
    localparam int unsigned   PRW      = PW + 21;
    localparam logic [PRW-1:0] RECIP   =
        PRW'(((1 << RECIP_SH) + ALIGN_UNIT - 1) / ALIGN_UNIT);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ALIGN, S_A_RD, S_A_HD, S_M_ADV, S_M_HD, S_SPLIT,
        S_WR2, S_POST, S_F_CHK, S_F_HD, S_FR_RD, S_FR_HD, S_FC_CHK, S_FC_HD,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [ffa_pkg::LIMIT_W-1:0] r_limit;
    logic [PW-1:0]              r_ff, n_ff;
    logic [PW-1:0]              r_cur, n_cur;
    logic [PW-1:0]              r_orig, n_orig;
    logic [PW-1:0]              r_size, n_size;
    logic [PW-1:0]              r_end, n_end;
    logic [WW-1:0]              r_wval, n_wval;
    logic [SW-1:0]              r_bsize, n_bsize;
    logic [SW-1:0]              r_total, n_total;
    logic                       r_post, n_post;
    logic [ffa_pkg::ADDR_W-1:0] r_res_addr, n_res_addr;
    ffa_pkg::t_status           r_res_st, n_res_st;
    logic                       r_ovalid, n_ovalid;
    logic [ffa_pkg::ADDR_W-1:0] r_oaddr, n_oaddr;
    ffa_pkg::t_status           r_ost, n_ost;

    logic                       w_en;
    logic [PW-1:0]              w_addr;
    logic [WW-1:0]              w_data;
    logic [PW-1:0]              rd_addr;
    logic [WW-1:0]              rd_data;
    logic [PW-1:0]              lim;

    // Effective limit: the smaller of the register and the heap depth
    assign lim = (PW'(r_limit) >= DEPTH_P) ? DEPTH_P : PW'(r_limit);

    ffa_ram #(.WIDTH(WW), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_en && (w_addr < DEPTH_P)),
        .i_waddr (w_addr[AW-1:0]),
        .i_wdata (w_data),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Request sequencer: next state, heap accesses and results
    always_comb begin
        logic [ffa_pkg::REQ_W-1:0] sz;
        logic [PW-1:0]             pos;
        logic [PRW-1:0]            prod;
        logic [SW-1:0]             wsz;
        n_state    = r_state;
        n_ff       = r_ff;
        n_cur      = r_cur;
        n_orig     = r_orig;
        n_size     = r_size;
        n_end      = r_end;
        n_wval     = r_wval;
        n_bsize    = r_bsize;
        n_total    = r_total;
        n_post     = r_post;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        n_ovalid   = r_ovalid & ~i_ready;
        n_oaddr    = r_oaddr;
        n_ost      = r_ost;
        w_en       = 1'b0;
        w_addr     = '0;
        w_data     = '0;
        rd_addr    = r_cur;
        o_ready    = 1'b0;
        sz         = '0;
        pos        = '0;
        prod       = '0;
        wsz        = rd_data[SW-1:0];

        unique case (r_state)
            // Place the end marker at word 0
            S_INIT: begin
                w_en    = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_res_addr = '0;
                    n_res_st   = ffa_pkg::ST_OK;
                    if (i_mode == ffa_pkg::MODE_ALLOC) begin
                        sz = (i_request_size == '0) ? ffa_pkg::ZERO_SIZE : i_request_size;
                        if (sz[ffa_pkg::USED_BIT]) begin
                            n_res_st = ffa_pkg::ST_REFUSED;
                            n_state  = S_DONE;
                        end else if (ALIGN_POW2) begin
                            n_size  = (PW'(sz) + ALIGN_P - PW'(1)) & ~(ALIGN_P - PW'(1));
                            n_cur   = r_ff;
                            n_state = S_A_RD;
                        end else begin
                            n_size  = PW'(sz) + ALIGN_P - PW'(1);
                            n_state = S_ALIGN;
                        end
                    end else begin
                        pos = PW'(i_block_address) - HDR_P;
                        if (i_block_address == '0 || PW'(i_block_address) < HDR_P ||
                            pos >= DEPTH_P) begin
                            n_state = S_DONE;
                        end else begin
                            n_orig  = pos;
                            n_state = S_FR_RD;
                        end
                    end
                end
            end
            // Round down to the alignment unit by reciprocal multiplication
            S_ALIGN: begin
                prod    = PRW'(r_size) * RECIP;
                n_size  = prod[RECIP_SH +: PW] * ALIGN_P;
                n_cur   = r_ff;
                n_state = S_A_RD;
            end
            // Allocate walk: fetch the header at cur
            S_A_RD: begin
                if (r_cur >= lim) begin
                    n_res_st = ffa_pkg::ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_A_HD;
                end
            end
            S_A_HD: begin
                if (rd_data == '0) begin
                    // End marker: extend the heap
                    pos = r_cur + HDR_P + r_size;
                    if (pos >= lim) begin
                        n_res_st = ffa_pkg::ST_OOM;
                        n_state  = S_DONE;
                    end else begin
                        w_en       = 1'b1;
                        w_addr     = r_cur;
                        w_data     = WW'(r_size) | (WW'(1) << ffa_pkg::USED_BIT);
                        n_end      = pos;
                        n_wval     = '0;
                        n_post     = 1'b0;
                        n_res_addr = ffa_pkg::ADDR_W'(r_cur + HDR_P);
                        if (r_cur == r_ff) begin
                            n_ff = pos;
                        end
                        n_state = S_WR2;
                    end
                end else if (rd_data[ffa_pkg::USED_BIT]) begin
                    n_cur   = r_cur + HDR_P + PW'(wsz);
                    n_state = S_A_RD;
                end else if (PW'(wsz) < r_size) begin
                    n_orig  = r_cur;
                    n_total = wsz;
                    n_bsize = wsz;
                    n_state = S_M_ADV;
                end else begin
                    n_bsize = wsz;
                    n_state = S_SPLIT;
                end
            end
            // Merge: step to the next neighbor and fetch it
            S_M_ADV: begin
                pos     = r_cur + HDR_P + PW'(r_bsize);
                n_cur   = pos;
                rd_addr = pos;
                if (pos >= lim) begin
                    n_res_st = ffa_pkg::ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_M_HD;
                end
            end
            S_M_HD: begin
                if (rd_data[ffa_pkg::USED_BIT]) begin
                    if (PW'(r_total) < r_size + HDR_P) begin
                        w_en    = 1'b1;
                        w_addr  = r_orig;
                        w_data  = WW'(r_total);
                        n_state = S_A_RD;
                    end else begin
                        n_cur   = r_orig;
                        n_bsize = r_total;
                        n_state = S_SPLIT;
                    end
                end else if (rd_data == '0) begin
                    // Merged run reaches the end: take the requested size
                    pos = r_orig + HDR_P + r_size;
                    if (pos >= lim) begin
                        n_res_st = ffa_pkg::ST_OOM;
                        n_state  = S_DONE;
                    end else begin
                        w_en    = 1'b1;
                        w_addr  = r_orig;
                        w_data  = WW'(r_size) | (WW'(1) << ffa_pkg::USED_BIT);
                        n_end   = pos;
                        n_wval  = '0;
                        n_post  = 1'b1;
                        n_cur   = r_orig;
                        n_state = S_WR2;
                    end
                end else begin
                    n_total = r_total + wsz + SW'(HEADER_WORDS);
                    n_bsize = wsz;
                    n_state = S_M_ADV;
                end
            end
            // Split an oversized block, then mark it used
            S_SPLIT: begin
                w_en   = 1'b1;
                w_addr = r_cur;
                if (PW'(r_bsize) > r_size + HDR_P + ALIGN_P) begin
                    w_data  = WW'(r_size) | (WW'(1) << ffa_pkg::USED_BIT);
                    n_end   = r_cur + HDR_P + r_size;
                    n_wval  = WW'(PW'(r_bsize) - r_size - HDR_P);
                    n_post  = 1'b1;
                    n_state = S_WR2;
                end else begin
                    w_data  = WW'(r_bsize) | (WW'(1) << ffa_pkg::USED_BIT);
                    n_state = S_POST;
                end
            end
            // Second header write (end marker or split remainder)
            S_WR2: begin
                w_en    = 1'b1;
                w_addr  = r_end;
                w_data  = r_wval;
                n_state = r_post ? S_POST : S_DONE;
            end
            S_POST: begin
                n_res_addr = ffa_pkg::ADDR_W'(r_cur + HDR_P);
                n_state    = (r_cur == r_ff) ? S_F_CHK : S_DONE;
            end
            // Advance first free past used blocks
            S_F_CHK: begin
                rd_addr = r_ff;
                n_state = (r_ff >= lim) ? S_DONE : S_F_HD;
            end
            S_F_HD: begin
                if (rd_data[ffa_pkg::USED_BIT]) begin
                    n_ff    = r_ff + PW'(wsz) + HDR_P;
                    n_state = S_F_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            // Free: read the block header
            S_FR_RD: begin
                rd_addr = r_orig;
                n_state = S_FR_HD;
            end
            S_FR_HD: begin
                n_bsize = wsz;
                if (r_orig < r_ff) begin
                    n_ff = r_orig;
                end
                n_cur   = r_orig + HDR_P + PW'(wsz);
                n_state = S_FC_CHK;
            end
            // Free: coalesce forward, header written once at the end
            S_FC_CHK: begin
                if (r_cur >= DEPTH_P) begin
                    w_en    = 1'b1;
                    w_addr  = r_orig;
                    w_data  = WW'(r_bsize);
                    n_state = S_DONE;
                end else begin
                    n_state = S_FC_HD;
                end
            end
            S_FC_HD: begin
                if (rd_data[ffa_pkg::USED_BIT]) begin
                    w_en    = 1'b1;
                    w_addr  = r_orig;
                    w_data  = WW'(r_bsize);
                    n_state = S_DONE;
                end else if (rd_data == '0) begin
                    w_en    = 1'b1;
                    w_addr  = r_orig;
                    n_state = S_DONE;
                end else begin
                    n_bsize = r_bsize + wsz + SW'(HEADER_WORDS);
                    n_cur   = r_cur + PW'(wsz) + HDR_P;
                    n_state = S_FC_CHK;
                end
            end
            // Hand the result to the output register
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_oaddr  = (r_res_st == ffa_pkg::ST_OK) ? r_res_addr : '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ff     <= '0;
            r_limit  <= ffa_pkg::LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ff     <= n_ff;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
        r_cur      <= n_cur;
        r_orig     <= n_orig;
        r_size     <= n_size;
        r_end      <= n_end;
        r_wval     <= n_wval;
        r_bsize    <= n_bsize;
        r_total    <= n_total;
        r_post     <= n_post;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_oaddr    <= n_oaddr;
        r_ost      <= n_ost;
    end

    assign o_valid        = r_ovalid;
    assign o_data_address = r_oaddr;
    assign o_status       = r_ost;

`ifndef ASSERT_OFF
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_ready)) |=> o_valid)
        else $error("finished result not presented");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ffa_pkg::ST_OK || o_status == ffa_pkg::ST_REFUSED ||
                     o_status == ffa_pkg::ST_OOM))
        else $error("undefined status code");
    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffa_pkg::ST_OK) |-> (o_data_address == '0))
        else $error("failed allocate returned an address");
`endif

endmodule

[rtl/ffa_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
module ffa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
